// File: src/mru_key_list_top_macros.svh
// Assertion macros for the MRU key list checker.
// Needs a clock named clk and an active-high reset named rst in scope.
`ifndef MRU_KEY_LIST_TOP_MACROS_SVH
`define MRU_KEY_LIST_TOP_MACROS_SVH

// checked only outside reset
`define MKL_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("mru_key_list port check failed");

// checked on every edge, reset included
`define MKL_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("mru_key_list port check failed");

`endif

// File: src/mkl_pkg.sv
// Shared types for the MRU key list: command codes and the
// controller/datapath command and status structs. No dependencies.
package mkl_pkg;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_READ   = 2'd3
  } mkl_cmd_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;   // input beat taken this cycle
    logic apply;    // commit the insert/remove shift
    logic rd_step;  // load next read beat into output register
  } mkl_ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;  // output register can take a beat
    logic rd_final;  // next read beat is the last one
  } mkl_sts_t;

endpackage

// File: src/mru_key_list_top.sv
// Top level of the MRU key list: stream ports, APB register port,
// controller and datapath. Depends on mkl_pkg, mkl_ctrl, mkl_datapath.
//
//  channel   direction  beat content
//  s_*       in         command and key
//  m_*       out        one list entry per beat, tlast on the final one
//  apb       in/out     capacity register at byte address 0
//
// Insert and remove compare the key in the accept cycle and shift the
// entry line in the next. Clear empties the list in its accept cycle.
// A read gives one beat per entry (one beat for an empty list), each
// beat loaded as soon as the output register is free.
// Synchronous reset: empty list, capacity 16. Entry contents need no reset.
// A stalled output holds its beat and the read waits with the input closed;
// once the final beat is loaded, new commands, reads included, are taken again.
module mru_key_list_top
  import mkl_pkg::*;
#(
  parameter int MAX_ENTRIES = 16,
  parameter int KEY_BITS    = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // cmd[1:0], key[33:2], zero pad
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // entry_key[31:0], position[35:32], zero pad
  output logic        m_tlast,
  output logic        m_tuser,   // empty_res
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  mkl_ctl_t    ctl;
  mkl_sts_t    sts;
  mkl_cmd_t    s_cmd;
  logic        cfg_we;
  logic [4:0]  capacity;
  logic [31:0] entry_key;
  logic [3:0]  position;

  assign s_cmd   = mkl_cmd_t'(s_tdata[1:0]);
  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
  assign prdata  = (paddr[2] == 1'b0) ? 32'(capacity) : 32'd0;
  assign m_tdata = {4'd0, position, entry_key};

  mkl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_cmd    (s_cmd),
    .s_tready (s_tready),
    .ctl      (ctl),
    .sts      (sts)
  );

  mkl_datapath #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .KEY_BITS    (KEY_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .s_cmd       (s_cmd),
    .s_key       (s_tdata[33:2]),
    .cfg_we      (cfg_we),
    .cfg_wdata   (pwdata[4:0]),
    .capacity    (capacity),
    .ctl         (ctl),
    .sts         (sts),
    .m_tready    (m_tready),
    .m_tvalid    (m_tvalid),
    .m_entry_key (entry_key),
    .m_position  (position),
    .m_last      (m_tlast),
    .m_empty     (m_tuser)
  );

endmodule

// File: src/mkl_ctrl.sv
// Sequencer for the MRU key list: accepts commands, steps the update
// and the read stream. Depends on mkl_pkg.
module mkl_ctrl
  import mkl_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     s_tvalid,
  input  mkl_cmd_t s_cmd,
  output logic     s_tready,
  output mkl_ctl_t ctl,
  input  mkl_sts_t sts
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_READ
  } state_t;

  state_t state;

  assign s_tready    = (state == ST_IDLE) && !rst;
  assign ctl.accept  = s_tvalid && s_tready;
  assign ctl.apply   = (state == ST_UPDATE);
  assign ctl.rd_step = (state == ST_READ) && sts.out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (ctl.accept) begin
            unique case (s_cmd)
              CMD_INSERT, CMD_REMOVE: state <= ST_UPDATE;
              CMD_READ:               state <= ST_READ;
              CMD_CLEAR:              state <= ST_IDLE;
              default:                state <= ST_IDLE;
            endcase
          end
        end
        ST_UPDATE: state <= ST_IDLE;
        ST_READ: begin
          if (ctl.rd_step && sts.rd_final) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: src/mkl_datapath.sv
// Datapath of the MRU key list: entry shift line, parallel key compare,
// prefix mask, fill count, capacity and output register. Depends on mkl_pkg.
module mkl_datapath
  import mkl_pkg::*;
#(
  parameter int MAX_ENTRIES = 16,
  parameter int KEY_BITS    = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  mkl_cmd_t    s_cmd,
  input  logic [31:0] s_key,
  input  logic        cfg_we,
  input  logic [4:0]  cfg_wdata,
  output logic [4:0]  capacity,
  input  mkl_ctl_t    ctl,
  output mkl_sts_t    sts,
  input  logic        m_tready,
  output logic        m_tvalid,
  output logic [31:0] m_entry_key,
  output logic [3:0]  m_position,
  output logic        m_last,
  output logic        m_empty
);

  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int LV = $clog2(MAX_ENTRIES);

  logic [KEY_BITS-1:0]    entries  [MAX_ENTRIES];
  logic [KEY_BITS-1:0]    ent_next [MAX_ENTRIES];
  logic [CW-1:0]          fill;
  logic [CW-1:0]          cap_eff;
  logic [CW-1:0]          rd_idx;
  mkl_cmd_t               op_q;
  logic [KEY_BITS-1:0]    key_q;
  logic [MAX_ENTRIES-1:0] hit;
  logic [MAX_ENTRIES-1:0] hit_q;
  logic [MAX_ENTRIES-1:0] pre [LV+1];
  logic [MAX_ENTRIES-1:0] incl;
  logic [63:0]            key_wide;
  logic [KEY_BITS-1:0]    key_k;
  logic [63:0]            ent_wide;

  assign key_wide = 64'(s_key);
  assign key_k    = key_wide[KEY_BITS-1:0];
  assign ent_wide = 64'(entries[0]);

  always_comb begin
    if (capacity == 5'd0) begin
      cap_eff = CW'(1);
    end else if (32'(capacity) > MAX_ENTRIES) begin
      cap_eff = CW'(MAX_ENTRIES);
    end else begin
      cap_eff = CW'(capacity);
    end
  end

  // compare against the live key in the accept cycle
  always_comb begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      hit[i] = (CW'(i) < fill) && (entries[i] == key_k);
    end
  end

  // incl[i]: a match sits at position i or at a lower index (log-depth prefix OR)
  always_comb begin
    pre[0] = hit_q;
    for (int l = 0; l < LV; l++) begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        pre[l+1][i] = pre[l][i];
        if (i >= (1 << l)) begin
          pre[l+1][i] = pre[l][i] | pre[l][i - (1 << l)];
        end
      end
    end
    incl = pre[LV];
  end

  assign sts.out_free = !m_tvalid || m_tready;
  assign sts.rd_final = (fill == '0) || (CW'(rd_idx + 1'b1) == fill);

  always_comb begin
    ent_next = entries;
    if (ctl.apply && op_q == CMD_INSERT) begin
      ent_next[0] = key_q;
      for (int i = 1; i < MAX_ENTRIES; i++) begin
        if (!incl[i-1]) ent_next[i] = entries[i-1];
      end
    end else if (ctl.apply && op_q == CMD_REMOVE) begin
      for (int i = 0; i < MAX_ENTRIES - 1; i++) begin
        if (incl[i]) ent_next[i] = entries[i+1];
      end
    end else if (ctl.rd_step && fill != '0) begin
      // rotate the filled part so the next entry lands at the head
      for (int i = 0; i < MAX_ENTRIES - 1; i++) begin
        if (CW'(i + 1) < fill) ent_next[i] = entries[i+1];
      end
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        if (CW'(i + 1) == fill) ent_next[i] = entries[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    entries <= ent_next;
    if (ctl.accept) begin
      op_q  <= s_cmd;
      key_q <= key_k;
      hit_q <= hit;
    end
    if (ctl.rd_step) begin
      if (fill == '0) begin
        m_entry_key <= '0;
        m_position  <= '0;
        m_last      <= 1'b1;
        m_empty     <= 1'b1;
      end else begin
        m_entry_key <= ent_wide[31:0];
        m_position  <= 4'(rd_idx);
        m_last      <= sts.rd_final;
        m_empty     <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= 5'd16;
      fill     <= '0;
      rd_idx   <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_we) begin
        capacity <= cfg_wdata;
      end

      if (cfg_we) begin
        fill <= '0;
      end else if (ctl.accept && s_cmd == CMD_CLEAR) begin
        fill <= '0;
      end else if (ctl.apply && op_q == CMD_INSERT) begin
        if (!(|hit_q) && fill < cap_eff) fill <= CW'(fill + 1'b1);
      end else if (ctl.apply && op_q == CMD_REMOVE) begin
        if (|hit_q) fill <= CW'(fill - 1'b1);
      end

      if (ctl.accept) begin
        rd_idx <= '0;
      end else if (ctl.rd_step) begin
        rd_idx <= CW'(rd_idx + 1'b1);
      end

      if (ctl.rd_step) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

// File: src/mkl_port_checker.sv
// Port-level checks for the MRU key list output stream, bound to the top.
// Depends on mru_key_list_top_macros.svh and mru_key_list_top.
`include "mru_key_list_top_macros.svh"

module mkl_port_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata,
  input logic        m_tlast,
  input logic        m_tuser
);

  logic [3:0] pos;

  assign pos = m_tdata[35:32];

  // stalled beat holds
  `MKL_ASSERT(a_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
  // empty-list beat is a lone final beat with zero data
  `MKL_ASSERT(a_empty, m_tvalid && m_tuser |-> m_tlast && (m_tdata == 40'd0))
  // positions count up inside one read
  `MKL_ASSERT(a_pos, m_tvalid && m_tready && !m_tlast |=> !m_tvalid || pos == $past(pos) + 4'd1)
  // nothing comes out right after reset
  `MKL_ASSERT_ALWAYS(a_rst, rst |=> !m_tvalid)

endmodule

bind mru_key_list_top mkl_port_checker u_port_checker (.*);

// File: tb/tb_top.sv
// Testbench for mru_key_list_top: drives command beats and capacity writes,
// predicts each read's list beats and checks them as they leave the block.
// Depends on mkl_pkg and the mru_key_list_top RTL.
`timescale 1ns / 100ps

module tb_top;
  import mkl_pkg::*;

  // Tracks the list as the block should hold it and queues the beats of each read.
  class mru_scoreboard;
    typedef struct packed {
      logic [31:0] key;
      logic [3:0]  pos;
      logic        last;
      logic        empty;
    } list_beat_t;

    logic [31:0] slots [16];
    int unsigned held;
    logic [4:0]  cap_reg;
    list_beat_t  expected_beats [$];
    int          mismatches;
    int          beats_checked;
    int          cap_writes;
    int          cmd_count [4];

    function new();
      held = 0;
      cap_reg = 5'd16;
      mismatches = 0;
      beats_checked = 0;
      cap_writes = 0;
      foreach (cmd_count[i]) cmd_count[i] = 0;
    endfunction

    task report(string msg);
      mismatches++;
      if (mismatches <= 40) $display("mismatch: %s", msg);
    endtask

    // 0 behaves as 1, anything above the store depth as the depth
    function int unsigned kept_max();
      if (cap_reg == 5'd0) return 1;
      if (cap_reg > 5'd16) return 16;
      return cap_reg;
    endfunction

    function void evict(logic [31:0] k);
      int unsigned i, j;
      for (i = 0; i < held; i++) begin
        if (slots[i] == k) begin
          for (j = i; j + 1 < held; j++) slots[j] = slots[j + 1];
          held--;
          return;
        end
      end
    endfunction

    function void add_front(logic [31:0] k);
      int unsigned j;
      if (held >= kept_max() && held > 0) held--;
      for (j = held; j > 0; j--) slots[j] = slots[j - 1];
      slots[0] = k;
      held++;
    endfunction

    function void set_capacity(logic [31:0] v);
      cap_reg = v[4:0];
      held = 0;
      cap_writes++;
    endfunction

    function void note_command(mkl_cmd_t cmd, logic [31:0] key);
      list_beat_t b;
      int unsigned i;
      cmd_count[int'(cmd)]++;
      case (cmd)
        CMD_INSERT: begin
          evict(key);
          add_front(key);
        end
        CMD_REMOVE: evict(key);
        CMD_CLEAR:  held = 0;
        default: begin
          if (held == 0) begin
            b = '0;
            b.last = 1'b1;
            b.empty = 1'b1;
            expected_beats.push_back(b);
          end else begin
            for (i = 0; i < held; i++) begin
              b = '0;
              b.key = slots[i];
              b.pos = i[3:0];
              b.last = (i + 1 == held);
              expected_beats.push_back(b);
            end
          end
        end
      endcase
    endfunction

    task check_beat(logic [39:0] data, logic tlast, logic tuser);
      list_beat_t want;
      if (expected_beats.size() == 0) begin
        report($sformatf("beat with nothing pending, key %h", data[31:0]));
        return;
      end
      want = expected_beats.pop_front();
      beats_checked++;
      if (data[31:0] !== want.key)
        report($sformatf("entry_key %h, want %h (pos %0d)", data[31:0], want.key, want.pos));
      if (data[35:32] !== want.pos)
        report($sformatf("position %0d, want %0d", data[35:32], want.pos));
      if (data[39:36] !== 4'd0)
        report($sformatf("pad bits %h not zero", data[39:36]));
      if (tlast !== want.last)
        report($sformatf("tlast %b, want %b (pos %0d)", tlast, want.last, want.pos));
      if (tuser !== want.empty)
        report($sformatf("empty flag %b, want %b", tuser, want.empty));
    endtask

    function int pending();
      return expected_beats.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;   // cmd[1:0], key[33:2], zero pad
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;        // entry_key[31:0], position[35:32], zero pad
  logic        m_tlast;
  logic        m_tuser;        // empty_res
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  mru_scoreboard sb = new();
  logic [31:0]   key_pool [$];
  bit            no_idle = 1'b0;
  int            hold_request = 0;

  mru_key_list_top dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tlast(m_tlast), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  initial begin
    #2000000;
    $display("FAIL mru_key_list_top");
    $finish;
  end

  // everything is sampled with the values seen at the edge
  always @(posedge clk) begin
    if (!rst) begin
      if (psel && penable && pwrite && pready) sb.set_capacity(pwdata);
      if (s_tvalid && s_tready) sb.note_command(mkl_cmd_t'(s_tdata[1:0]), s_tdata[33:2]);
      if (m_tvalid && m_tready) sb.check_beat(m_tdata, m_tlast, m_tuser);
    end
  end

  function int draw_gap();
    if (no_idle) return 0;
    if ($urandom_range(0, 1) == 0) return 0;
    return $urandom_range(0, 19);
  endfunction

  // output side: per-beat stall, plus a long hold when one is requested
  initial begin
    int gap;
    forever begin
      if (hold_request > 0) begin
        m_tready <= 1'b0;
        repeat (hold_request) @(posedge clk);
        hold_request = 0;
      end
      gap = draw_gap();
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid && hold_request == 0);
    end
  end

  task send_cmd(mkl_cmd_t cmd, logic [31:0] key);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {6'd0, key, cmd};
    do @(posedge clk); while (!s_tready);
  endtask

  // stop sending and let every pending beat arrive, then let the last
  // insert or remove settle
  task drain();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (sb.pending() != 0);
    repeat (8) @(posedge clk);
  endtask

  task write_capacity(logic [31:0] v);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 3'd0;
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  function void fill_pool(int n);
    key_pool.delete();
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 3))
        0: key_pool.push_back($urandom_range(0, 15));
        default: key_pool.push_back($urandom());
      endcase
    end
  endfunction

  function logic [31:0] pick_key();
    if ($urandom_range(0, 9) == 0) return $urandom();
    return key_pool[$urandom_range(0, key_pool.size() - 1)];
  endfunction

  task random_phase(int n, int pause_at);
    int r;
    mkl_cmd_t cmd;
    for (int i = 0; i < n; i++) begin
      if (i == pause_at) drain();
      r = $urandom_range(0, 99);
      if (r < 50) cmd = CMD_INSERT;
      else if (r < 70) cmd = CMD_REMOVE;
      else if (r < 96) cmd = CMD_READ;
      else cmd = CMD_CLEAR;
      send_cmd(cmd, pick_key());
    end
  endtask

  initial begin
    logic [31:0] caps [10];
    int unsigned eff;
    caps = '{32'd16, 32'd3, 32'd0, 32'd31, 32'd17, 32'd8, 32'd1, 32'd15, 32'd2, 32'd16};

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty read, extreme keys, move to front, remove hit and miss
    send_cmd(CMD_READ, 32'h0);
    send_cmd(CMD_INSERT, 32'h0000_0000);
    send_cmd(CMD_INSERT, 32'hFFFF_FFFF);
    send_cmd(CMD_INSERT, 32'h8000_0000);
    send_cmd(CMD_INSERT, 32'h0000_0001);
    send_cmd(CMD_READ, 32'hFFFF_FFFF);
    send_cmd(CMD_INSERT, 32'hFFFF_FFFF);
    send_cmd(CMD_READ, 32'h0);
    send_cmd(CMD_REMOVE, 32'h0000_0000);
    send_cmd(CMD_REMOVE, 32'h1234_5678);
    send_cmd(CMD_READ, 32'h0);
    send_cmd(CMD_CLEAR, 32'hFFFF_FFFF);
    send_cmd(CMD_READ, 32'h0);
    send_cmd(CMD_REMOVE, 32'h0000_0005);
    send_cmd(CMD_INSERT, 32'h5555_AAAA);
    drain();
    // capacity write clears the list; capacity 1 keeps only the newest
    write_capacity(32'd1);
    send_cmd(CMD_READ, 32'h0);
    send_cmd(CMD_INSERT, 32'h0000_0007);
    send_cmd(CMD_INSERT, 32'h0000_0009);
    send_cmd(CMD_INSERT, 32'h0000_0007);
    send_cmd(CMD_READ, 32'h0);
    drain();
    write_capacity(32'd2);
    send_cmd(CMD_INSERT, 32'h0000_000A);
    send_cmd(CMD_INSERT, 32'h0000_000B);
    send_cmd(CMD_INSERT, 32'h0000_000C);
    send_cmd(CMD_READ, 32'h0);
    drain();

    for (int p = 0; p < 10; p++) begin
      write_capacity(caps[p]);
      eff = (caps[p] == 0) ? 1 : (caps[p] > 16) ? 16 : caps[p];
      fill_pool(eff + $urandom_range(2, 6));
      no_idle = (p == 5);
      if (p == 9) hold_request = 300;
      random_phase(36, (p == 2) ? 18 : -1);
      drain();
    end
    no_idle = 1'b0;

    repeat (20) @(posedge clk);
    $display("run covered %0d inserts, %0d removes, %0d clears, %0d reads, %0d capacity writes",
             sb.cmd_count[0], sb.cmd_count[1], sb.cmd_count[2], sb.cmd_count[3],
             sb.cap_writes);
    $display("%0d list beats checked, %0d mismatches", sb.beats_checked, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("PASS mru_key_list_top");
    end else begin
      $display("FAIL mru_key_list_top");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+src
src/mkl_pkg.sv
src/mkl_ctrl.sv
src/mkl_datapath.sv
src/mru_key_list_top.sv
src/mkl_port_checker.sv
tb/tb_top.sv
